@@ hw/rtl/periodic_image_contact_finder_macros.svh @@
// assertion macros for the contact finder
`ifndef PERIODIC_IMAGE_CONTACT_FINDER_MACROS_SVH
`define PERIODIC_IMAGE_CONTACT_FINDER_MACROS_SVH

`ifndef SYNTHESIS
`define PCF_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pcf assertion failed");
`define PCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcf assertion failed");
`else
`define PCF_ASSERT(lbl, clk, rst_n, cond)
`define PCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/pcf_pkg.sv @@
package pcf_pkg;

  localparam int MAX_ATOMS   = 64;
  localparam int IMAGE_REACH = 1;
  localparam int NIMG        = 2 * IMAGE_REACH + 1;

  localparam int IW   = $clog2(MAX_ATOMS);
  localparam int CW   = $clog2(MAX_ATOMS + 1);
  localparam int POSW = 24;
  localparam int BOXW = 23;
  localparam int DW   = POSW + 1;
  localparam int VW   = DW + 2;
  localparam int AW   = VW - 1;
  localparam int SQW  = 52;
  localparam int OIW  = 6;

  // configuration register indexes
  localparam logic [1:0] REG_BOX_X  = 2'd0;
  localparam logic [1:0] REG_BOX_Y  = 2'd1;
  localparam logic [1:0] REG_BOX_Z  = 2'd2;
  localparam logic [1:0] REG_CUTOFF = 2'd3;

  typedef logic [2:0][POSW-1:0] pos_t;
  typedef logic [2:0][BOXW-1:0] box_t;

  // token that walks through the distance unit
  typedef struct packed {
    logic          vld;
    logic          fin;
    logic [IW-1:0] idx;
  } pcf_ctl_t;

endpackage

@@ hw/rtl/periodic_image_contact_finder.sv @@
// contacts: a contact leaves when the next contact of its atom is found, the last of a
//   run when the end token leaves the distance unit
// intake: a new atom is taken only after one full turn of the atom ring past the
//   single distance unit plus its drain
// output stalls hold the ring and the distance unit
// reset: atom count and configuration clear, stored atoms are not cleared
`include "periodic_image_contact_finder_macros.svh"

module periodic_image_contact_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // pos_x, pos_y, pos_z
  input  logic        s_axis_tuser_i,  // frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // first_atom, second_atom, dist_squared
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [51:0] cfg_data_i
);
  import pcf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e         state_q;
  box_t           box_q;
  logic [SQW-1:0] cutoff_q;
  logic [CW-1:0]  count_q, step_q, cnt_eff;
  logic [IW-1:0]  cur_q;
  pos_t           probe_q;
  pos_t           cell_pos [MAX_ATOMS];
  logic           adv, accept, rot, fin_issue;
  pcf_ctl_t       ctl_in, ctl_end;
  logic           hit;
  logic [SQW-1:0] dist_sq;
  logic           pend_v_q;
  logic [IW-1:0]  pend_idx_q;
  logic [SQW-1:0] pend_dist_q;
  logic           m_valid_q, m_last_q;
  logic [63:0]    m_data_q;

  assign adv             = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_eff         = s_axis_tuser_i ? '0 : count_q;
  assign rot             = (state_q == ST_SWEEP) && adv && (step_q != CW'(MAX_ATOMS));
  assign fin_issue       = (state_q == ST_SWEEP) && adv && (step_q == CW'(MAX_ATOMS));

  // token into the distance unit
  always_comb begin
    ctl_in     = '0;
    ctl_in.vld = rot && (step_q < count_q);
    ctl_in.fin = fin_issue;
    ctl_in.idx = step_q[IW-1:0];
  end

  // ring of stored atoms, head at cell 0
  for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
    pcf_cell u_cell (
      .clk_i  (clk_i),
      .rot_i  (rot),
      .ld_i   (fin_issue && (cur_q == IW'(i))),
      .nb_i   (cell_pos[(i + 1) % MAX_ATOMS]),
      .probe_i(probe_q),
      .pos_o  (cell_pos[i])
    );
  end

  pcf_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .ctl_i   (ctl_in),
    .probe_i (probe_q),
    .head_i  (cell_pos[0]),
    .box_i   (box_q),
    .cutoff_i(cutoff_q),
    .ctl_o   (ctl_end),
    .hit_o   (hit),
    .dist_o  (dist_sq)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q    <= '0;
      cutoff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_X:  box_q[0] <= cfg_data_i[BOXW-1:0];
        REG_BOX_Y:  box_q[1] <= cfg_data_i[BOXW-1:0];
        REG_BOX_Z:  box_q[2] <= cfg_data_i[BOXW-1:0];
        REG_CUTOFF: cutoff_q <= cfg_data_i;
        default:    cutoff_q <= cutoff_q;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
      cur_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            count_q <= cnt_eff;
            if (cnt_eff != CW'(MAX_ATOMS)) begin
              cur_q   <= cnt_eff[IW-1:0];
              step_q  <= '0;
              state_q <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (rot) begin
            step_q <= step_q + 1'b1;
          end else if (fin_issue) begin
            count_q <= count_q + 1'b1;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (adv && ctl_end.fin) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // new atom coordinates
  always_ff @(posedge clk_i) begin
    if (accept) begin
      probe_q <= s_axis_tdata_i;
    end
  end

  // one contact held back so the last of a run can be marked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else if (adv) begin
      if (ctl_end.vld && hit) begin
        pend_v_q  <= 1'b1;
        m_valid_q <= pend_v_q;
        m_last_q  <= 1'b0;
      end else if (ctl_end.fin && pend_v_q) begin
        pend_v_q  <= 1'b0;
        m_valid_q <= 1'b1;
        m_last_q  <= 1'b1;
      end else begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // contact payload
  always_ff @(posedge clk_i) begin
    if (adv && ((ctl_end.vld && hit) || ctl_end.fin) && pend_v_q) begin
      m_data_q <= {pend_dist_q, OIW'(cur_q), OIW'(pend_idx_q)};
    end
    if (adv && ctl_end.vld && hit) begin
      pend_idx_q  <= ctl_end.idx;
      pend_dist_q <= dist_sq;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // checks
  `PCF_ASSERT(a_idle_no_pend, clk_i, rst_ni, (state_q != ST_IDLE) || !pend_v_q)
  `PCF_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(MAX_ATOMS))
  `PCF_ASSERT_NEXT(a_full_ignored, clk_i, rst_ni,
                   accept && !s_axis_tuser_i && (count_q == CW'(MAX_ATOMS)),
                   state_q == ST_IDLE)
  `PCF_ASSERT_NEXT(a_fin_ends_sweep, clk_i, rst_ni, fin_issue, state_q == ST_DRAIN)

endmodule

@@ hw/rtl/pcf_cell.sv @@
module pcf_cell (
  input  logic          clk_i,
  input  logic          rot_i,
  input  logic          ld_i,
  input  pcf_pkg::pos_t nb_i,
  input  pcf_pkg::pos_t probe_i,
  output pcf_pkg::pos_t pos_o
);
  import pcf_pkg::*;

  pos_t pos_q;

  // one stored atom: shifts toward the head or takes the new atom
  always_ff @(posedge clk_i) begin
    if (rot_i) begin
      pos_q <= nb_i;
    end else if (ld_i) begin
      pos_q <= probe_i;
    end
  end

  assign pos_o = pos_q;

endmodule

@@ hw/rtl/pcf_dist.sv @@
module pcf_dist (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  pcf_pkg::pcf_ctl_t        ctl_i,
  input  pcf_pkg::pos_t            probe_i,
  input  pcf_pkg::pos_t            head_i,
  input  pcf_pkg::box_t            box_i,
  input  logic [pcf_pkg::SQW-1:0]  cutoff_i,
  output pcf_pkg::pcf_ctl_t        ctl_o,
  output logic                     hit_o,
  output logic [pcf_pkg::SQW-1:0]  dist_o
);
  import pcf_pkg::*;

  pcf_ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic signed [VW-1:0] v_d [3][NIMG];
  logic signed [VW-1:0] v_q [3][NIMG];
  logic [SQW-1:0]       sq_d [3][NIMG];
  logic [SQW-1:0]       sq_q [3][NIMG];
  logic [SQW-1:0]       mn_d [3];
  logic [SQW-1:0]       mn_q [3];
  logic [SQW+1:0]       sum;
  logic                 hit_q;
  logic [SQW-1:0]       dist_q;

  // image candidates per axis: difference plus (k - IMAGE_REACH) times box length
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < NIMG; k++) begin
        v_d[a][k] = VW'($signed({probe_i[a][POSW-1], probe_i[a]})
                      - $signed({head_i[a][POSW-1], head_i[a]}))
                  + VW'($signed(VW'(k - IMAGE_REACH)) * $signed(VW'(box_i[a])));
      end
    end
  end

  // magnitude and square of every candidate
  always_comb begin
    logic [VW-1:0] mag;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < NIMG; k++) begin
        mag = v_q[a][k][VW-1] ? VW'(-v_q[a][k]) : VW'(v_q[a][k]);
        sq_d[a][k] = SQW'(mag[AW-1:0]) * SQW'(mag[AW-1:0]);
      end
    end
  end

  // smallest square per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mn_d[a] = sq_q[a][0];
      for (int k = 1; k < NIMG; k++) begin
        if (sq_q[a][k] < mn_d[a]) begin
          mn_d[a] = sq_q[a][k];
        end
      end
    end
  end

  assign sum = (SQW+2)'(mn_q[0]) + (SQW+2)'(mn_q[1]) + (SQW+2)'(mn_q[2]);

  // control tokens
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      hit_q  <= 1'b0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      hit_q  <= ctl3_q.vld && (sum[SQW-1:0] <= cutoff_i);
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q    <= v_d;
      sq_q   <= sq_d;
      mn_q   <= mn_d;
      dist_q <= sum[SQW-1:0];
    end
  end

  assign ctl_o  = ctl4_q;
  assign hit_o  = hit_q;
  assign dist_o = dist_q;

endmodule
